FILE: rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg: shared definitions for the midpoint circle generator
// Widths, decision constants, step codes and the step record that runs
// from the front end through the step queue to the point emitter.
// ----------------------------------------------------------------------------
package mcg_pkg;

	localparam int COORD_BITS  = 12;
	localparam int RADIUS_BITS = COORD_BITS - 1;
	localparam int DEC_BITS    = COORD_BITS + 4;
	localparam int OUT_BITS    = COORD_BITS + 1;
	localparam int CMP_BITS    = COORD_BITS + 2;

	localparam int S_TDATA_BITS = ((RADIUS_BITS + 2 * COORD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int POINTS      = 8;
	localparam int PT_BITS     = $clog2(POINTS);

	localparam logic FUNC_START   = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	localparam logic [DEC_BITS-1:0] D_INIT    = DEC_BITS'(3);
	localparam logic [DEC_BITS-1:0] D_INC_NEG = DEC_BITS'(6);
	localparam logic [DEC_BITS-1:0] D_INC_POS = DEC_BITS'(10);

	typedef struct packed {
		logic [COORD_BITS-1:0]        x;
		logic [COORD_BITS-1:0]        y;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic                         done;
	} step_t;

endpackage

FILE: rtl/mcg_front.sv
// ----------------------------------------------------------------------------
// mcg_front: command front end
// Accepts start and advance beats, holds the circle state, runs the midpoint
// decision update and pushes one step record per emitting beat.
// ----------------------------------------------------------------------------
module mcg_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// radius, center_x, center_y, zero fill
	input  logic [mcg_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
	// func
	input  logic [0:0]                           s_axis_tuser,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output mcg_pkg::step_t                       push_data
);
	import mcg_pkg::*;

	logic [COORD_BITS-1:0]        x_q, y_q;
	logic [DEC_BITS-1:0]          d_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic                         active_q;

	logic [RADIUS_BITS-1:0]       radius;
	logic signed [COORD_BITS-1:0] in_cx, in_cy;
	logic                         start, accept;
	logic [COORD_BITS-1:0]        cur_x, cur_y, nx, ny;
	logic [DEC_BITS-1:0]          cur_d, d_next, x_ext, y_ext;
	logic signed [COORD_BITS-1:0] cur_cx, cur_cy;
	logic                         neg, done;
	logic [CMP_BITS-1:0]          xp1, ylim;

	assign radius = s_axis_tdata[RADIUS_BITS-1:0];
	assign in_cx  = s_axis_tdata[RADIUS_BITS +: COORD_BITS];
	assign in_cy  = s_axis_tdata[RADIUS_BITS+COORD_BITS +: COORD_BITS];
	assign start  = (s_axis_tuser[0] == FUNC_START);

	assign s_axis_tready = push_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push_valid    = accept && (start || active_q);

	always_comb begin
		cur_x  = start ? '0 : x_q;
		cur_y  = start ? COORD_BITS'(radius) : y_q;
		cur_d  = start ? (D_INIT - (DEC_BITS'(radius) << 1)) : d_q;
		cur_cx = start ? in_cx : cx_q;
		cur_cy = start ? in_cy : cy_q;
		neg    = cur_d[DEC_BITS-1];
		x_ext  = DEC_BITS'(cur_x);
		y_ext  = DEC_BITS'(cur_y);
		d_next = neg ? (cur_d + (x_ext << 2) + D_INC_NEG)
		             : (cur_d + ((x_ext - y_ext) << 2) + D_INC_POS);
		nx     = cur_x + COORD_BITS'(1);
		ny     = neg ? cur_y : (cur_y - COORD_BITS'(1));
		xp1    = CMP_BITS'(cur_x) + CMP_BITS'(1);
		ylim   = CMP_BITS'(cur_y) - (neg ? CMP_BITS'(0) : CMP_BITS'(1));
		done   = $signed(xp1) > $signed(ylim);
	end

	assign push_data = '{x: cur_x, y: cur_y, cx: cur_cx, cy: cur_cy, done: done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			active_q <= 1'b0;
		end else if (push_valid) begin
			x_q      <= nx;
			y_q      <= ny;
			d_q      <= d_next;
			cx_q     <= cur_cx;
			cy_q     <= cur_cy;
			active_q <= !done;
		end
	end

endmodule

FILE: rtl/mcg_queue.sv
// ----------------------------------------------------------------------------
// mcg_queue: step record queue
// Short first-in first-out buffer that decouples the front end from the
// point emitter.
// ----------------------------------------------------------------------------
module mcg_queue #(
	parameter int DEPTH = mcg_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mcg_pkg::step_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mcg_pkg::step_t pop_data
);
	import mcg_pkg::*;

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	step_t               mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                push, pop;

	assign push_ready = (cnt_q != CNT_BITS'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

endmodule

FILE: rtl/mcg_back.sv
// ----------------------------------------------------------------------------
// mcg_back: point emitter
// Walks the eight octant mirrors of the head step record, one point per
// cycle while the output stage is free or its beat is taken, into a registered output stage.
// ----------------------------------------------------------------------------
module mcg_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  mcg_pkg::step_t                   pop_data,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// point_x, point_y, zero fill
	output logic [mcg_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	// circle_done
	output logic [0:0]                       m_axis_tuser
);
	import mcg_pkg::*;

	logic [PT_BITS-1:0]         k_q;
	logic                       valid_q;
	logic signed [OUT_BITS-1:0] px_q, py_q;
	logic                       last_q, done_q;

	logic                       load, last_pt;
	logic signed [OUT_BITS-1:0] x13, y13, cx13, cy13, ox, oy;

	assign load      = pop_valid && (!valid_q || m_axis_tready);
	assign last_pt   = (k_q == PT_BITS'(POINTS - 1));
	assign pop_ready = load && last_pt;

	always_comb begin
		x13  = OUT_BITS'(pop_data.x);
		y13  = OUT_BITS'(pop_data.y);
		cx13 = OUT_BITS'(pop_data.cx);
		cy13 = OUT_BITS'(pop_data.cy);
		unique case (k_q)
			3'd0:    begin ox = x13;  oy = y13;  end
			3'd1:    begin ox = y13;  oy = x13;  end
			3'd2:    begin ox = y13;  oy = -x13; end
			3'd3:    begin ox = x13;  oy = -y13; end
			3'd4:    begin ox = -x13; oy = -y13; end
			3'd5:    begin ox = -y13; oy = -x13; end
			3'd6:    begin ox = -y13; oy = x13;  end
			default: begin ox = -x13; oy = y13;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q     <= k_q + PT_BITS'(1);
				valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q   <= cx13 + ox;
			py_q   <= cy13 + oy;
			last_q <= last_pt;
			done_q <= pop_data.done;
		end
	end

	assign m_axis_tvalid   = valid_q;
	assign m_axis_tdata    = M_TDATA_BITS'({py_q, px_q});
	assign m_axis_tlast    = last_q;
	assign m_axis_tuser[0] = done_q;

endmodule

FILE: rtl/midpoint_circle_generator.sv
// ----------------------------------------------------------------------------
// midpoint_circle_generator: midpoint circle rasterizer
// Usage:
//   s_axis carries commands: tuser[0] = 0 starts a circle from the radius and
//   center in tdata, tuser[0] = 1 advances one step. Each emitting command
//   yields eight points on m_axis in octant order; tlast marks the eighth,
//   tuser[0] flags the step after which the circle is complete.
//   An advance with no circle in progress is consumed and yields nothing;
//   a start always abandons any circle in progress.
// Timing:
//   A command's step record is written into the step queue, and the emitter
//   then registers its first point into the output stage. One point per
//   cycle while m_axis_tready is high, so a steady command stream is paced
//   by the output channel. The step queue holds up to QUEUE_DEPTH pending
//   steps; commands are taken back to back while it has room.
// Reset and stall:
//   arst_n clears the circle state, the queue and the output stage.
//   When m_axis_tready is low the output beat holds, the emitter stops,
//   the queue fills and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module midpoint_circle_generator #(
	parameter int QUEUE_DEPTH = mcg_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// radius[10:0], center_x[22:11], center_y[34:23], zero fill
	input  logic [mcg_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
	// func
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// point_x[12:0], point_y[25:13], zero fill
	output logic [mcg_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	// circle_done
	output logic [0:0]                       m_axis_tuser
);
	import mcg_pkg::*;

	logic  push_valid, push_ready, pop_valid, pop_ready;
	step_t push_data, pop_data;

	mcg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	mcg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mcg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the midpoint circle generator
// Drives start and advance commands on the input stream: a short table of
// corner cases, then random circles run to completion or cut short. A local
// circle state model predicts points, save the axis points of table start
// rows; output is compared field by field against the oldest predicted point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import mcg_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 16;
	localparam int RANDOM_STEPS = 300;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_AXES,
		CHK_SILENT
	} row_check_e;

	typedef struct packed {
		logic                         func;
		logic [RADIUS_BITS-1:0]       radius;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		row_check_e                   chk;
		logic                         done;
	} stim_row_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] px;
		logic signed [OUT_BITS-1:0] py;
		logic                       last;
		logic                       done;
	} point_t;

	localparam int NUM_ROWS = 23;

	stim_row_t dir_rows [0:NUM_ROWS-1] = '{
		'{FUNC_ADVANCE, 11'h7ff, 12'hfff, 12'hfff, CHK_SILENT, 1'b0},
		'{FUNC_START,   11'd0,   12'h000, 12'h000, CHK_AXES,   1'b1},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_SILENT, 1'b0},
		'{FUNC_START,   11'd1,   12'h000, 12'h000, CHK_AXES,   1'b1},
		'{FUNC_ADVANCE, 11'h7ff, 12'h7ff, 12'h800, CHK_SILENT, 1'b0},
		'{FUNC_START,   11'h7ff, 12'h7ff, 12'h7ff, CHK_AXES,   1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_ADVANCE, 11'h7ff, 12'hfff, 12'hfff, CHK_MODEL,  1'b0},
		'{FUNC_START,   11'h7ff, 12'h800, 12'h800, CHK_AXES,   1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_START,   11'd5,   12'h800, 12'h7ff, CHK_AXES,   1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_START,   11'h555, 12'h555, 12'haaa, CHK_AXES,   1'b0},
		'{FUNC_START,   11'h2aa, 12'haaa, 12'h555, CHK_AXES,   1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_START,   11'd3,   12'sd100, -12'sd100, CHK_AXES, 1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0},
		'{FUNC_ADVANCE, 11'd0,   12'h000, 12'h000, CHK_MODEL,  1'b0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	// radius[10:0], center_x[22:11], center_y[34:23], zero fill
	logic [S_TDATA_BITS-1:0] s_axis_tdata;
	// func
	logic [0:0]              s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	// point_x[12:0], point_y[25:13], zero fill
	logic [M_TDATA_BITS-1:0] m_axis_tdata;
	logic                    m_axis_tlast;
	// circle_done
	logic [0:0]              m_axis_tuser;

	point_t points_due[$];
	int     mismatches = 0;
	int     burst_left = 0;
	int     steps_sent = 0;

	logic [COORD_BITS-1:0]        walk_x;
	logic [COORD_BITS-1:0]        walk_y;
	logic signed [DEC_BITS-1:0]   walk_d;
	logic signed [COORD_BITS-1:0] hold_cx;
	logic signed [COORD_BITS-1:0] hold_cy;
	logic                         circle_on;

	midpoint_circle_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int step_circle(input logic func, input logic [RADIUS_BITS-1:0] r,
			input logic signed [COORD_BITS-1:0] cx, input logic signed [COORD_BITS-1:0] cy,
			input bit keep);
		int     x;
		int     y;
		int     d;
		int     nd;
		int     ny;
		bit     dn;
		int     ox [8];
		int     oy [8];
		point_t p;
		if (func == FUNC_START) begin
			hold_cx   = cx;
			hold_cy   = cy;
			walk_x    = '0;
			walk_y    = COORD_BITS'(r);
			walk_d    = DEC_BITS'(3 - 2 * int'(r));
			circle_on = 1'b1;
		end else if (!circle_on) begin
			return 0;
		end
		x  = int'(walk_x);
		y  = int'(walk_y);
		d  = int'(walk_d);
		ny = y;
		if (d < 0) begin
			nd = d + 4 * x + 6;
		end else begin
			nd = d + 4 * (x - y) + 10;
			ny = y - 1;
		end
		dn = (x + 1) > ((ny != y) ? y - 1 : y);
		ox = '{x, y, y, x, -x, -y, -y, -x};
		oy = '{y, x, -x, -y, -y, -x, x, y};
		if (keep) begin
			for (int k = 0; k < POINTS; k++) begin
				p.px   = OUT_BITS'(int'(hold_cx) + ox[k]);
				p.py   = OUT_BITS'(int'(hold_cy) + oy[k]);
				p.last = (k == POINTS - 1);
				p.done = dn;
				points_due.push_back(p);
			end
		end
		walk_x = COORD_BITS'(x + 1);
		walk_y = COORD_BITS'(ny);
		walk_d = DEC_BITS'(nd);
		if (dn)
			circle_on = 1'b0;
		return POINTS;
	endfunction

	task automatic send_beat(input logic func, input logic [RADIUS_BITS-1:0] r,
			input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy, input bit keep);
		int n;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_TDATA_BITS'({cy, cx, r});
		s_axis_tuser  <= func;
		do
			@(posedge clk);
		while (!s_axis_tready);
		burst_left--;
		n = step_circle(func, r, $signed(cx), $signed(cy), keep);
		if (n != 0)
			steps_sent++;
	endtask

	task automatic drain_points();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (points_due.size() != 0);
	endtask

	initial begin
		int        rx_left;
		int        rx_mode;
		rx_left = 0;
		rx_mode = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = (rx_mode == 3) ? $urandom_range(5, 40) : $urandom_range(16, 200);
			end
			rx_left--;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin : check_points
		point_t want;
		logic signed [OUT_BITS-1:0] got_x;
		logic signed [OUT_BITS-1:0] got_y;
		got_x = m_axis_tdata[OUT_BITS-1:0];
		got_y = m_axis_tdata[2*OUT_BITS-1:OUT_BITS];
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (points_due.size() == 0) begin
				$display("%0t: unexpected point beat: expected none, actual x=%0d y=%0d",
					$time, got_x, got_y);
				mismatches++;
			end else begin
				want = points_due.pop_front();
				if (got_x !== want.px) begin
					$display("%0t: point_x expected %0d actual %0d", $time, want.px, got_x);
					mismatches++;
				end
				if (got_y !== want.py) begin
					$display("%0t: point_y expected %0d actual %0d", $time, want.py, got_y);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last_of_group expected %0b actual %0b", $time, want.last,
						m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser[0] !== want.done) begin
					$display("%0t: circle_done expected %0b actual %0b", $time, want.done,
						m_axis_tuser[0]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		stim_row_t row;
		point_t    p;
		int        ax [8];
		int        ay [8];
		bit        big;
		int        radius;
		int        steps;
		ax = '{0, 1, 1, 0, 0, -1, -1, 0};
		ay = '{1, 0, 0, -1, -1, 0, 0, 1};
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		walk_x    = '0;
		walk_y    = '0;
		walk_d    = '0;
		hold_cx   = '0;
		hold_cy   = '0;
		circle_on = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = dir_rows[i];
			send_beat(row.func, row.radius, row.cx, row.cy, row.chk == CHK_MODEL);
			if (row.chk == CHK_AXES) begin
				for (int k = 0; k < POINTS; k++) begin
					p.px   = OUT_BITS'(int'(row.cx) + ax[k] * int'(row.radius));
					p.py   = OUT_BITS'(int'(row.cy) + ay[k] * int'(row.radius));
					p.last = (k == POINTS - 1);
					p.done = row.done;
					points_due.push_back(p);
				end
			end
		end
		drain_points();

		steps_sent = 0;
		while (steps_sent < RANDOM_STEPS) begin
			big    = ($urandom_range(0, 4) == 0);
			radius = big ? $urandom_range(0, 2047) : $urandom_range(0, 40);
			if (big)
				steps = $urandom_range(0, 8);
			else if ($urandom_range(0, 6) == 0)
				steps = $urandom_range(0, 5);
			else
				steps = 4 * RADIUS_BITS * RADIUS_BITS;
			send_beat(FUNC_START, RADIUS_BITS'(radius), COORD_BITS'($urandom),
				COORD_BITS'($urandom), 1'b1);
			for (int i = 0; i < steps && circle_on; i++)
				send_beat(FUNC_ADVANCE, RADIUS_BITS'($urandom), COORD_BITS'($urandom),
					COORD_BITS'($urandom), 1'b1);
			if (!circle_on)
				repeat ($urandom_range(0, 2))
					send_beat(FUNC_ADVANCE, RADIUS_BITS'($urandom), COORD_BITS'($urandom),
						COORD_BITS'($urandom), 1'b1);
			if ($urandom_range(0, 19) == 0)
				drain_points();
		end
		drain_points();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: midpoint_circle_generator.f
rtl/mcg_pkg.sv
rtl/mcg_front.sv
rtl/mcg_queue.sv
rtl/mcg_back.sv
rtl/midpoint_circle_generator.sv
tb/tb.sv
